### rtl/core/can_target_route_cache_macros.svh
`ifndef CAN_TARGET_ROUTE_CACHE_MACROS_SVH
`define CAN_TARGET_ROUTE_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctrc check failed");

// Next-cycle implication, checked outside reset.
`define CTRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctrc check failed");

`endif

### rtl/core/ctrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctrc_pkg;

    localparam int ADDR_W   = 11;
    localparam int HDR_W    = 29;
    localparam int BUS_W    = 2;
    localparam int RATE_W   = 8;
    localparam int COUNT_W  = 2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [BUS_W-1:0]  t_bus;

    localparam t_bus BUS_C1 = 2'd0;
    localparam t_bus BUS_C2 = 2'd1;
    localparam t_bus BUS_BH = 2'd2;

    localparam logic OP_QUERY    = 1'b0;
    localparam logic OP_REMEMBER = 1'b1;

    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_HIT  = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_MISS = 2'd3;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

    typedef struct packed {
        logic fin;
        logic hit;
        logic query;
        t_bus bus;
    } t_fin;

    function automatic t_addr target_of(input logic [HDR_W-1:0] header, input logic ext);
        t_addr addr;
        if (ext) begin
            addr = {3'b000, header[15:8]};
        end else begin
            addr = header[ADDR_W-1:0];
        end
        return addr;
    endfunction

endpackage
`default_nettype wire

### rtl/core/can_target_route_cache.sv
// A query or remember word walks the table from slot 0, one slot per cycle, through the
// single compare unit; a hit ends the walk at that slot, a miss after all filled slots.
// No new word is accepted until the walk ends and its result has entered the output
// register, which waits while the previous result is not yet taken by the receiver.
// Reset (i_rst_n low, synchronous): empties the cache (fill count zero), idles the
// sequencer and drops any pending result; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module can_target_route_cache #(
    parameter int CACHE_ENTRIES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_opcode,
    input  wire [28:0]  i_header_id,
    input  wire         i_header_is_extended,
    input  wire [7:0]   i_rate_divisor,
    input  wire [1:0]   i_learned_bus,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_candidate_count,
    output logic        o_found,
    output logic [1:0]  o_first_bus,
    output logic [1:0]  o_second_bus,
    output logic [1:0]  o_third_bus
);
    import ctrc_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int FW = $clog2(CACHE_ENTRIES + 1);

    logic          busy, start, out_free;
    t_fin          fin;
    t_tbl_ctl      tbl;
    logic [IW-1:0] rd_idx, wr_idx;
    t_addr         wr_addr, rd_addr;
    t_bus          wr_bus, rd_bus;

    logic              r_slow;
    logic              r_out_valid;
    logic [COUNT_W-1:0] r_count;
    logic              r_found;
    t_bus              r_first, r_second, r_third;

    assign o_in_ready = !busy;
    assign start      = i_in_valid && !busy;
    assign out_free   = !r_out_valid || i_out_ready;

    ctrc_ctrl #(
        .CACHE_ENTRIES(CACHE_ENTRIES),
        .IW(IW),
        .FW(FW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_op(i_opcode),
        .i_target(target_of(i_header_id, i_header_is_extended)),
        .i_bus(i_learned_bus),
        .i_out_free(out_free),
        .o_busy(busy),
        .o_fin(fin),
        .o_tbl(tbl),
        .o_rd_idx(rd_idx),
        .o_wr_idx(wr_idx),
        .o_wr_addr(wr_addr),
        .o_wr_bus(wr_bus),
        .i_rd_addr(rd_addr),
        .i_rd_bus(rd_bus)
    );

    ctrc_table #(
        .CACHE_ENTRIES(CACHE_ENTRIES),
        .IW(IW)
    ) u_table (
        .i_clk(i_clk),
        .i_ctl(tbl),
        .i_rd_idx(rd_idx),
        .i_wr_idx(wr_idx),
        .i_wr_addr(wr_addr),
        .i_wr_bus(wr_bus),
        .o_rd_addr(rd_addr),
        .o_rd_bus(rd_bus)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_slow <= (i_rate_divisor > 8'd1);
        end
        if (fin.fin) begin
            r_count  <= CNT_NONE;
            r_found  <= 1'b0;
            r_first  <= BUS_C1;
            r_second <= BUS_C1;
            r_third  <= BUS_C1;
            if (fin.query) begin
                if (fin.hit) begin
                    r_count <= CNT_HIT;
                    r_found <= 1'b1;
                    r_first <= fin.bus;
                end else begin
                    r_count  <= CNT_MISS;
                    r_first  <= r_slow ? BUS_BH : BUS_C1;
                    r_second <= BUS_C2;
                    r_third  <= r_slow ? BUS_C1 : BUS_BH;
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_candidate_count = r_count;
    assign o_found           = r_found;
    assign o_first_bus       = r_first;
    assign o_second_bus      = r_second;
    assign o_third_bus       = r_third;

endmodule
`default_nettype wire

### rtl/core/ctrc_table.sv
`timescale 1ns / 1ps
`default_nettype none
module ctrc_table #(
    parameter int CACHE_ENTRIES = 8,
    parameter int IW = 3
) (
    input  wire                 i_clk,
    input  ctrc_pkg::t_tbl_ctl  i_ctl,
    input  wire [IW-1:0]        i_rd_idx,
    input  wire [IW-1:0]        i_wr_idx,
    input  ctrc_pkg::t_addr     i_wr_addr,
    input  ctrc_pkg::t_bus      i_wr_bus,
    output ctrc_pkg::t_addr     o_rd_addr,
    output ctrc_pkg::t_bus      o_rd_bus
);
    import ctrc_pkg::*;

    t_addr r_mem_addr [CACHE_ENTRIES];
    t_bus  r_mem_bus  [CACHE_ENTRIES];
    t_addr r_rd_addr;
    t_bus  r_rd_bus;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_addr[i_wr_idx] <= i_wr_addr;
            r_mem_bus[i_wr_idx]  <= i_wr_bus;
        end
        if (i_ctl.rd_en) begin
            r_rd_addr <= r_mem_addr[i_rd_idx];
            r_rd_bus  <= r_mem_bus[i_rd_idx];
        end
    end

    assign o_rd_addr = r_rd_addr;
    assign o_rd_bus  = r_rd_bus;

endmodule
`default_nettype wire

### rtl/core/ctrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "can_target_route_cache_macros.svh"
module ctrc_ctrl #(
    parameter int CACHE_ENTRIES = 8,
    parameter int IW = 3,
    parameter int FW = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_op,
    input  ctrc_pkg::t_addr     i_target,
    input  ctrc_pkg::t_bus      i_bus,
    input  wire                 i_out_free,
    output logic                o_busy,
    output ctrc_pkg::t_fin      o_fin,
    output ctrc_pkg::t_tbl_ctl  o_tbl,
    output logic [IW-1:0]       o_rd_idx,
    output logic [IW-1:0]       o_wr_idx,
    output ctrc_pkg::t_addr     o_wr_addr,
    output ctrc_pkg::t_bus      o_wr_bus,
    input  ctrc_pkg::t_addr     i_rd_addr,
    input  ctrc_pkg::t_bus      i_rd_bus
);
    import ctrc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;
    localparam logic [FW-1:0] FULL = FW'(CACHE_ENTRIES);

    logic          r_state, n_state;
    logic [FW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pslot, n_pslot;
    logic          r_op;
    t_addr         r_target;
    t_bus          r_bus;

    logic hit, fin_cond, fin, issue;

    always_comb begin
        hit      = r_pend && (i_rd_addr == r_target);
        fin_cond = hit || (r_idx == r_fill);
        fin      = (r_state == S_SCAN) && fin_cond && i_out_free;
        issue    = (r_state == S_SCAN) && !fin_cond;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_fill  = r_fill;
        n_pend  = r_pend;
        n_pslot = r_pslot;
        o_tbl.rd_en = issue;
        o_tbl.wr_en = 1'b0;
        o_rd_idx  = r_idx[IW-1:0];
        o_wr_idx  = r_pslot;
        o_wr_addr = r_target;
        o_wr_bus  = r_bus;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx   = r_idx + 1'b1;
                    n_pend  = 1'b1;
                    n_pslot = r_idx[IW-1:0];
                end else if (fin) begin
                    n_state = S_IDLE;
                    n_pend  = 1'b0;
                    if (r_op == OP_REMEMBER) begin
                        if (hit) begin
                            o_tbl.wr_en = 1'b1;
                        end else if (r_fill != FULL) begin
                            o_tbl.wr_en = 1'b1;
                            o_wr_idx    = r_fill[IW-1:0];
                            n_fill      = r_fill + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pslot <= n_pslot;
        if (i_start) begin
            r_op     <= i_op;
            r_target <= i_target;
            r_bus    <= i_bus;
        end
    end

    assign o_busy    = (r_state == S_SCAN);
    assign o_fin.fin   = fin;
    assign o_fin.hit   = hit;
    assign o_fin.query = (r_op == OP_QUERY);
    assign o_fin.bus   = i_rd_bus;

    `CTRC_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL)
    `CTRC_ASSERT_NOW(a_read_below_fill, i_clk, i_rst_n, o_tbl.rd_en, r_idx < r_fill)
    `CTRC_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE)
    `CTRC_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n,
        fin && !hit && (r_op == OP_REMEMBER) && (r_fill != FULL),
        r_fill == $past(r_fill) + 1'b1)

endmodule
`default_nettype wire

### verif/can_target_route_cache_test.sv
`timescale 1ns / 1ps
module can_target_route_cache_test;
    import ctrc_pkg::*;

    localparam int SLOTS        = 8;
    localparam int RESET_CYCLES = 12;
    localparam int PER_PHASE    = 163;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRINT_CAP    = 50;

    localparam t_bus BUS_SPARE = 2'd3;
    localparam bit   BY_TABLE  = 1'b1;
    localparam bit   BY_MODEL  = 1'b0;

    typedef struct packed {
        logic               opcode;
        logic [HDR_W-1:0]   header;
        logic               ext;
        logic [RATE_W-1:0]  divisor;
        t_bus               bus;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        t_bus               first;
        t_bus               second;
        t_bus               third;
    } route_t;

    typedef struct {
        req_t   req;
        bit     by_table;
        route_t want;
    } row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_opcode = 1'b0;
    logic [28:0]        i_header_id = '0;
    logic               i_header_is_extended = 1'b0;
    logic [7:0]         i_rate_divisor = '0;
    logic [1:0]         i_learned_bus = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_candidate_count;
    logic               o_found;
    logic [1:0]         o_first_bus;
    logic [1:0]         o_second_bus;
    logic [1:0]         o_third_bus;

    // predictor copy of the cache
    t_addr       slot_addr [SLOTS];
    t_bus        slot_bus [SLOTS];
    int unsigned slots_used = 0;

    route_t route_queue [$];
    row_t   plan_rows [$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int errors        = 0;
    int words_checked = 0;
    int cycle_count   = 0;
    int n_hit         = 0;
    int n_miss        = 0;
    int n_remember    = 0;
    int n_dropped     = 0;

    always #2 i_clk = ~i_clk;

    can_target_route_cache #(
        .CACHE_ENTRIES(SLOTS)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_opcode             (i_opcode),
        .i_header_id          (i_header_id),
        .i_header_is_extended (i_header_is_extended),
        .i_rate_divisor       (i_rate_divisor),
        .i_learned_bus        (i_learned_bus),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_candidate_count    (o_candidate_count),
        .o_found              (o_found),
        .o_first_bus          (o_first_bus),
        .o_second_bus         (o_second_bus),
        .o_third_bus          (o_third_bus)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %0d, want %0d (word %0d)",
                     $time, what, got, want, words_checked);
        end
    endtask

    function automatic route_t predict_route(input req_t r);
        t_addr  a;
        int     hit_slot;
        route_t res;
        a = r.ext ? {3'b000, r.header[15:8]} : r.header[ADDR_W-1:0];
        hit_slot = -1;
        res = '0;
        for (int i = 0; i < slots_used; i++) begin
            if (hit_slot < 0 && slot_addr[i] == a) begin
                hit_slot = i;
            end
        end
        if (r.opcode == OP_REMEMBER) begin
            n_remember++;
            if (hit_slot >= 0) begin
                slot_bus[hit_slot] = r.bus;
            end else if (slots_used < SLOTS) begin
                slot_addr[slots_used] = a;
                slot_bus[slots_used]  = r.bus;
                slots_used++;
            end else begin
                n_dropped++;
            end
        end else if (hit_slot >= 0) begin
            n_hit++;
            res.count = CNT_HIT;
            res.found = 1'b1;
            res.first = slot_bus[hit_slot];
        end else begin
            n_miss++;
            res.count = CNT_MISS;
            if (r.divisor > 1) begin
                res.first  = BUS_BH;
                res.second = BUS_C2;
                res.third  = BUS_C1;
            end else begin
                res.first  = BUS_C1;
                res.second = BUS_C2;
                res.third  = BUS_BH;
            end
        end
        return res;
    endfunction

    function automatic req_t random_word();
        req_t        r;
        t_addr       a;
        int unsigned pick;
        bit          steer;
        r.opcode = ($urandom_range(99) < 40) ? OP_REMEMBER : OP_QUERY;
        r.header = HDR_W'($urandom);
        r.ext    = 1'($urandom_range(1));
        r.bus    = BUS_W'($urandom_range(3));
        case ($urandom_range(5))
            0: begin
                r.divisor = 8'd0;
            end
            1: begin
                r.divisor = 8'd1;
            end
            2: begin
                r.divisor = 8'd2;
            end
            3: begin
                r.divisor = 8'hFF;
            end
            default: begin
                r.divisor = RATE_W'($urandom);
            end
        endcase
        a = '0;
        steer = 1'b1;
        pick = $urandom_range(99);
        if (pick < 55 && slots_used > 0) begin
            a = slot_addr[$urandom_range(slots_used - 1)];
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0: begin
                    a = 11'h000;
                end
                1: begin
                    a = 11'h7FF;
                end
                2: begin
                    a = 11'h0FF;
                end
                default: begin
                    a = 11'h100;
                end
            endcase
        end else begin
            steer = 1'b0;
        end
        if (steer) begin
            if (r.ext && a[10:8] == 3'b000) begin
                r.header[15:8] = a[7:0];
            end else begin
                r.ext = 1'b0;
                r.header[ADDR_W-1:0] = a;
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic op, input logic [HDR_W-1:0] hdr,
                                    input logic ext, input logic [RATE_W-1:0] div,
                                    input t_bus bus, input bit by_table,
                                    input logic [COUNT_W-1:0] cnt, input logic fnd,
                                    input t_bus b1, input t_bus b2, input t_bus b3);
        row_t row;
        row.req      = '{op, hdr, ext, div, bus};
        row.by_table = by_table;
        row.want     = '{cnt, fnd, b1, b2, b3};
        plan_rows.push_back(row);
    endfunction

    task automatic send_word(input req_t r, input bit by_table, input route_t want);
        route_t res;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_opcode             <= r.opcode;
        i_header_id          <= r.header;
        i_header_is_extended <= r.ext;
        i_rate_divisor       <= r.divisor;
        i_learned_bus        <= r.bus;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        res = predict_route(r);
        route_queue.push_back(by_table ? want : res);
    endtask

    // result check and receiver stall
    always @(posedge i_clk) begin
        route_t got;
        route_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_candidate_count, o_found, o_first_bus, o_second_bus, o_third_bus};
            if (route_queue.size() == 0) begin
                report_mismatch("word with no result pending", 1, 0);
            end else begin
                want = route_queue.pop_front();
                if (got.count !== want.count)
                    report_mismatch("candidate_count", int'(got.count), int'(want.count));
                if (got.found !== want.found)
                    report_mismatch("found", int'(got.found), int'(want.found));
                if (got.first !== want.first)
                    report_mismatch("first_bus", int'(got.first), int'(want.first));
                if (got.second !== want.second)
                    report_mismatch("second_bus", int'(got.second), int'(want.second));
                if (got.third !== want.third)
                    report_mismatch("third_bus", int'(got.third), int'(want.third));
                words_checked++;
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, route_queue.size());
            $display("** can_target_route_cache: FAILED **");
            $finish;
        end
    end

    initial begin
        int in_pct [4];
        int out_pct [4];
        in_pct  = '{0, 61, 0, 25};
        out_pct = '{0, 0, 61, 25};

        // miss orders on an empty cache
        add_row(OP_QUERY, 29'h0000000, 1'b0, 8'd0, BUS_C1, BY_TABLE,
                CNT_MISS, 1'b0, BUS_C1, BUS_C2, BUS_BH);
        add_row(OP_QUERY, 29'h1FFFFFFF, 1'b1, 8'd1, BUS_BH, BY_TABLE,
                CNT_MISS, 1'b0, BUS_C1, BUS_C2, BUS_BH);
        add_row(OP_QUERY, 29'h00007FF, 1'b0, 8'd2, BUS_C2, BY_TABLE,
                CNT_MISS, 1'b0, BUS_BH, BUS_C2, BUS_C1);
        add_row(OP_QUERY, 29'h0000155, 1'b0, 8'hFF, BUS_SPARE, BY_TABLE,
                CNT_MISS, 1'b0, BUS_BH, BUS_C2, BUS_C1);
        // upper header bits ignored
        add_row(OP_REMEMBER, 29'h1FFFFFFF, 1'b0, 8'hFF, BUS_C1, BY_TABLE,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h00007FF, 1'b0, 8'd0, BUS_BH, BY_TABLE,
                CNT_HIT, 1'b1, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h000FF00, 1'b1, 8'd0, BUS_BH, BY_TABLE,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        // bus code three stored as given
        add_row(OP_REMEMBER, 29'h0000000, 1'b0, 8'd0, BUS_SPARE, BY_TABLE,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h1FFFF800, 1'b0, 8'd2, BUS_C1, BY_TABLE,
                CNT_HIT, 1'b1, BUS_SPARE, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h00007FF, 1'b0, 8'd0, BUS_C2, BY_TABLE,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h00007FF, 1'b0, 8'hFF, BUS_C1, BY_TABLE,
                CNT_HIT, 1'b1, BUS_C2, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h1FFFFFFF, 1'b1, 8'd0, BUS_C1, BY_TABLE,
                CNT_HIT, 1'b1, BUS_BH, BUS_C1, BUS_C1);
        // standard header aliasing an extended address
        add_row(OP_QUERY, 29'h00000FF, 1'b0, 8'd1, BUS_C2, BY_TABLE,
                CNT_HIT, 1'b1, BUS_BH, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h1FFF00FF, 1'b1, 8'd7, BUS_BH, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        // fill the cache, then one more address gets dropped
        add_row(OP_REMEMBER, 29'h0000001, 1'b0, 8'd0, BUS_C2, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h0000002, 1'b0, 8'd9, BUS_BH, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h0000400, 1'b0, 8'd0, BUS_C1, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h0ABCD555, 1'b0, 8'd1, BUS_C2, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h00002AA, 1'b0, 8'd0, BUS_BH, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_REMEMBER, 29'h0000123, 1'b0, 8'd0, BUS_C2, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h0000123, 1'b0, 8'd3, BUS_C1, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);
        add_row(OP_QUERY, 29'h15555AAA, 1'b0, 8'd0, BUS_C1, BY_MODEL,
                CNT_NONE, 1'b0, BUS_C1, BUS_C1, BUS_C1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_rows[k]) begin
            send_word(plan_rows[k].req, plan_rows[k].by_table, plan_rows[k].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            in_idle_pct   = in_pct[ph];
            out_stall_pct = out_pct[ph];
            for (int n = 0; n < PER_PHASE; n++) begin
                send_word(random_word(), BY_MODEL, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (route_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d words: %0d query hits, %0d query misses, %0d remember words",
                 words_checked, n_hit, n_miss, n_remember);
        $display("%0d remembers dropped on a full cache; four idle/stall mixes, %0d errors",
                 n_dropped, errors);
        if (errors == 0) begin
            $display("** can_target_route_cache: PASSED **");
        end else begin
            $display("** can_target_route_cache: FAILED **");
        end
        $finish;
    end

endmodule
